>>> sv/pll_divider_code_encoder_assert.svh
// ----------------------------------------------------------------------------
// pll divider code encoder assertion macros
// concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef PLL_DIVIDER_CODE_ENCODER_ASSERT_SVH
`define PLL_DIVIDER_CODE_ENCODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked only outside reset
`define PDCE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define PDCE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define PDCE_ASSERT(label, prop, msg)
`define PDCE_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

>>> sv/pdce_pkg.sv
// ----------------------------------------------------------------------------
// pdce_pkg
// shared types, constants and lfsr step functions of the pll code encoder
// ----------------------------------------------------------------------------
package pdce_pkg;

  // field widths
  localparam int unsigned MultW   = 16;
  localparam int unsigned PredivW = 9;
  localparam int unsigned PostW   = 6;
  localparam int unsigned MCodeW  = 20;
  localparam int unsigned NCodeW  = 12;
  localparam int unsigned PCodeW  = 8;
  localparam int unsigned SelPW   = 5;
  localparam int unsigned SelIW   = 6;

  // step counter widths
  localparam int unsigned MCntW = 15;
  localparam int unsigned NCntW = 8;
  localparam int unsigned PCntW = 5;

  // divider for 1024 / (m + 9)
  localparam int unsigned DivQW   = 11;
  localparam int unsigned DivRemW = 10;
  localparam int unsigned DivDW   = 9;
  localparam int unsigned DivCntW = 4;
  localparam logic [DivCntW-1:0] DivSteps = 4'd11;

  // range limits
  localparam logic [MultW:0]   MMax = 17'h08000;
  localparam logic [PredivW:0] NMax = 10'h100;
  localparam logic [PostW:0]   PMax = 7'h20;

  // seeds
  localparam logic [MCodeW-1:0] MSeed = 20'h04000;
  localparam logic [NCodeW-1:0] NSeed = 12'h080;
  localparam logic [PCodeW-1:0] PSeed = 8'h10;

  // fixed words for values 0, 1 and 2
  localparam logic [MCodeW-1:0] MWord0 = 20'hFFFFF;
  localparam logic [MCodeW-1:0] MWord1 = 20'h18003;
  localparam logic [MCodeW-1:0] MWord2 = 20'h10003;
  localparam logic [NCodeW-1:0] NWord0 = 12'hFFF;
  localparam logic [NCodeW-1:0] NWord1 = 12'h302;
  localparam logic [NCodeW-1:0] NWord2 = 12'h202;
  localparam logic [PCodeW-1:0] PWord0 = 8'hFF;
  localparam logic [PCodeW-1:0] PWord1 = 8'h62;
  localparam logic [PCodeW-1:0] PWord2 = 8'h42;

  // filter selection thresholds
  localparam logic [MultW-1:0] MSelHigh  = 16'd16384;
  localparam logic [MultW-1:0] MSelMid   = 16'd8192;
  localparam logic [MultW-1:0] MSelLow   = 16'd2048;
  localparam logic [MultW-1:0] MSelFixed = 16'd501;
  localparam logic [MultW-1:0] MSelDiv   = 16'd60;
  localparam logic [DivDW-1:0] MDivOfs   = 9'd9;
  localparam logic [SelPW-1:0] SelPMax   = 5'd31;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic run;
    logic capture;
  } pdce_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic busy;
  } pdce_sts_t;

  // one result beat
  typedef struct packed {
    logic              sel_r;
    logic [SelIW-1:0]  sel_i;
    logic [SelPW-1:0]  sel_p;
    logic [PCodeW-1:0] p_code;
    logic [NCodeW-1:0] n_code;
    logic [MCodeW-1:0] m_code;
  } pdce_result_t;

  // 15-bit lfsr, new bit = b0 ^ b1
  function automatic logic [MCodeW-1:0] lfsr_m_step(input logic [MCodeW-1:0] x);
    return {5'b0, x[0] ^ x[1], x[14:1]};
  endfunction

  // 8-bit lfsr, new bit = b0 ^ b2 ^ b3 ^ b4
  function automatic logic [NCodeW-1:0] lfsr_n_step(input logic [NCodeW-1:0] x);
    return {4'b0, x[0] ^ x[2] ^ x[3] ^ x[4], x[7:1]};
  endfunction

  // 5-bit lfsr, new bit = b0 ^ b2
  function automatic logic [PCodeW-1:0] lfsr_p_step(input logic [PCodeW-1:0] x);
    return {3'b0, x[0] ^ x[2], x[4:1]};
  endfunction

endpackage

>>> sv/pll_divider_code_encoder.sv
// ----------------------------------------------------------------------------
// pll_divider_code_encoder
// encodes pll multiplier, pre-divider and post-divider into lfsr code words
// and loop filter selections
// ----------------------------------------------------------------------------
// channel  dir  fields (low bit up)
// s_axis   in   mult_m[15:0] prediv_n[24:16] postdiv_p[30:25] pad[31]
// m_axis   out  m_code[19:0] n_code[31:20] p_code[39:32] sel_p[44:40]
//               sel_i[50:45] sel_r[51] pad[55:52]
//
// result registered once the m, n and p lfsr steps and the divider are done; the
// next beat is taken after capture; the longest run is set by the m lfsr counter
// the 11-step serial divider for the integral selection runs alongside
// a result waits in the output register while the next item is accepted
// an item finished while the output register is still full holds until taken
// reset clears the controller and step counters; no clearing pass
// ----------------------------------------------------------------------------
module pll_divider_code_encoder
  import pdce_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // mult_m, prediv_n, postdiv_p, pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // m_code, n_code, p_code, sel_p, sel_i, sel_r, pad
);

  pdce_cmd_t    cmd;
  pdce_sts_t    sts;
  pdce_result_t result;

  // controller
  pdce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // datapath
  pdce_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .mult_m_i    (s_axis_tdata[15:0]),
    .prediv_n_i  (s_axis_tdata[24:16]),
    .postdiv_p_i (s_axis_tdata[30:25]),
    .result_o    (result)
  );

  // pack result beat
  assign m_axis_tdata = {4'b0, result};

endmodule

>>> sv/pdce_datapath.sv
// ----------------------------------------------------------------------------
// pdce_datapath
// lfsr registers with step counters, serial divider and result register
// ----------------------------------------------------------------------------
`include "pll_divider_code_encoder_assert.svh"

module pdce_datapath
  import pdce_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pdce_cmd_t            cmd_i,
  output pdce_sts_t            sts_o,
  input  logic [MultW-1:0]     mult_m_i,
  input  logic [PredivW-1:0]   prediv_n_i,
  input  logic [PostW-1:0]     postdiv_p_i,
  output pdce_result_t         result_o
);

  logic [MCodeW-1:0]  m_lfsr_q, m_lfsr_d;
  logic [NCodeW-1:0]  n_lfsr_q, n_lfsr_d;
  logic [PCodeW-1:0]  p_lfsr_q, p_lfsr_d;
  logic [MCntW-1:0]   m_cnt_q, m_cnt_d;
  logic [NCntW-1:0]   n_cnt_q, n_cnt_d;
  logic [PCntW-1:0]   p_cnt_q, p_cnt_d;
  logic [MultW-1:0]   m_val_q, m_val_d;
  logic [DivDW-1:0]   div_d_q, div_d_d;
  logic [DivRemW-1:0] div_rem_q, div_rem_d;
  logic [DivQW-1:0]   div_quo_q, div_quo_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  pdce_result_t       result_q, result_d;

  logic [DivRemW:0]   div_trial;
  logic               div_ge;
  logic [MultW:0]     m_steps;
  logic [PredivW:0]   n_steps;
  logic [PostW:0]     p_steps;
  logic [SelPW-1:0]   sel_p;
  logic [SelIW-1:0]   sel_i;

  // step counts: max - value + 1, none outside 3..max
  always_comb begin
    m_steps = MMax - {1'b0, mult_m_i} + 17'd1;
    n_steps = NMax - {1'b0, prediv_n_i} + 10'd1;
    p_steps = PMax - {1'b0, postdiv_p_i} + 7'd1;
    if (({1'b0, mult_m_i} > MMax) || (mult_m_i < 16'd3)) m_steps = '0;
    if (({1'b0, prediv_n_i} > NMax) || (prediv_n_i < 9'd3)) n_steps = '0;
    if (({1'b0, postdiv_p_i} > PMax) || (postdiv_p_i < 6'd3)) p_steps = '0;
  end

  // restoring division step, dividend bit set only on the first step
  always_comb begin
    div_trial = {div_rem_q, (div_cnt_q == DivSteps)};
    div_ge    = div_trial >= {2'b0, div_d_q};
  end

  // loop filter selections from the held multiplier
  always_comb begin
    sel_p = (m_val_q < MSelDiv) ? (m_val_q[5:1] + 5'd1) : SelPMax;
    priority if (m_val_q > MSelHigh) begin
      sel_i = 6'd1;
    end else if (m_val_q > MSelMid) begin
      sel_i = 6'd2;
    end else if (m_val_q > MSelLow) begin
      sel_i = 6'd4;
    end else if (m_val_q >= MSelFixed) begin
      sel_i = 6'd8;
    end else if (m_val_q >= MSelDiv) begin
      sel_i = {div_quo_q[3:0], 2'b00};
    end else begin
      sel_i = {m_val_q[5:2], 2'b00} + 6'd4;
    end
  end

  // load, step and capture
  always_comb begin
    m_lfsr_d  = m_lfsr_q;
    n_lfsr_d  = n_lfsr_q;
    p_lfsr_d  = p_lfsr_q;
    m_cnt_d   = m_cnt_q;
    n_cnt_d   = n_cnt_q;
    p_cnt_d   = p_cnt_q;
    m_val_d   = m_val_q;
    div_d_d   = div_d_q;
    div_rem_d = div_rem_q;
    div_quo_d = div_quo_q;
    div_cnt_d = div_cnt_q;
    result_d  = result_q;
    if (cmd_i.load) begin
      m_val_d   = mult_m_i;
      div_d_d   = mult_m_i[DivDW-1:0] + MDivOfs;
      div_rem_d = '0;
      div_quo_d = '0;
      div_cnt_d = DivSteps;
      m_cnt_d   = m_steps[MCntW-1:0];
      n_cnt_d   = n_steps[NCntW-1:0];
      p_cnt_d   = p_steps[PCntW-1:0];
      unique case (mult_m_i)
        16'd0:   m_lfsr_d = MWord0;
        16'd1:   m_lfsr_d = MWord1;
        16'd2:   m_lfsr_d = MWord2;
        default: m_lfsr_d = MSeed;
      endcase
      unique case (prediv_n_i)
        9'd0:    n_lfsr_d = NWord0;
        9'd1:    n_lfsr_d = NWord1;
        9'd2:    n_lfsr_d = NWord2;
        default: n_lfsr_d = NSeed;
      endcase
      unique case (postdiv_p_i)
        6'd0:    p_lfsr_d = PWord0;
        6'd1:    p_lfsr_d = PWord1;
        6'd2:    p_lfsr_d = PWord2;
        default: p_lfsr_d = PSeed;
      endcase
    end else if (cmd_i.run) begin
      if (m_cnt_q != '0) begin
        m_lfsr_d = lfsr_m_step(m_lfsr_q);
        m_cnt_d  = m_cnt_q - 1'b1;
      end
      if (n_cnt_q != '0) begin
        n_lfsr_d = lfsr_n_step(n_lfsr_q);
        n_cnt_d  = n_cnt_q - 1'b1;
      end
      if (p_cnt_q != '0) begin
        p_lfsr_d = lfsr_p_step(p_lfsr_q);
        p_cnt_d  = p_cnt_q - 1'b1;
      end
      if (div_cnt_q != '0) begin
        div_cnt_d = div_cnt_q - 1'b1;
        div_quo_d = {div_quo_q[DivQW-2:0], div_ge};
        div_rem_d = div_ge ? DivRemW'(div_trial - {2'b0, div_d_q})
                           : div_trial[DivRemW-1:0];
      end
    end
    if (cmd_i.capture) begin
      result_d.m_code = m_lfsr_q;
      result_d.n_code = n_lfsr_q;
      result_d.p_code = p_lfsr_q;
      result_d.sel_p  = sel_p;
      result_d.sel_i  = sel_i;
      result_d.sel_r  = 1'b0;
    end
  end

  // counters are control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_cnt_q   <= '0;
      n_cnt_q   <= '0;
      p_cnt_q   <= '0;
      div_cnt_q <= '0;
    end else begin
      m_cnt_q   <= m_cnt_d;
      n_cnt_q   <= n_cnt_d;
      p_cnt_q   <= p_cnt_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    m_lfsr_q  <= m_lfsr_d;
    n_lfsr_q  <= n_lfsr_d;
    p_lfsr_q  <= p_lfsr_d;
    m_val_q   <= m_val_d;
    div_d_q   <= div_d_d;
    div_rem_q <= div_rem_d;
    div_quo_q <= div_quo_d;
    result_q  <= result_d;
  end

  assign sts_o.busy = (m_cnt_q != '0) || (n_cnt_q != '0) || (p_cnt_q != '0) ||
                      (div_cnt_q != '0);
  assign result_o   = result_q;

  // assertions
  `PDCE_ASSERT(a_div_cnt_range, div_cnt_q <= DivSteps, "divider count out of range")
  `PDCE_ASSERT(a_m_cnt_dec,
    (cmd_i.run && !cmd_i.load && m_cnt_q != '0) |=> (m_cnt_q == $past(m_cnt_q) - 1'b1),
    "m step counter did not count down")
  `PDCE_ASSERT(a_capture_idle, cmd_i.capture |-> !sts_o.busy,
    "result captured while lfsr or divider still busy")

endmodule

>>> sv/pdce_ctrl.sv
// ----------------------------------------------------------------------------
// pdce_ctrl
// controller: takes an input beat, runs the datapath, hands off the result
// ----------------------------------------------------------------------------
`include "pll_divider_code_encoder_assert.svh"

module pdce_ctrl
  import pdce_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output pdce_cmd_t cmd_o,
  input  pdce_sts_t sts_i
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StRun;
        end
      end
      StRun: begin
        cmd_o.run = 1'b1;
        if (!sts_i.busy && (!out_valid_q || out_ready_i)) begin
          cmd_o.capture = 1'b1;
          state_d       = StIdle;
        end
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.capture) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // assertions
  `PDCE_ASSERT(a_no_overwrite, cmd_o.capture |-> (!out_valid_q || out_ready_i),
    "result register overwritten before it was taken")
  `PDCE_ASSERT(a_capture_sets_valid, cmd_o.capture |=> out_valid_q,
    "captured result not presented")
  `PDCE_ASSERT(a_load_then_run, cmd_o.load |=> (state_q == StRun && !in_ready_o),
    "accepted beat did not start a run")

endmodule
